@@ sv/grc_pkg.sv @@
// ----------------------------------------------------------------------------
// grc_pkg: shared types and constants of the grid ray caster
// Map geometry, fixed-point widths, item structs and controller commands.
// ----------------------------------------------------------------------------
package grc_pkg;

  // map geometry (dimensions and cell size are powers of two)
  localparam int MAP_WIDTH  = 32;
  localparam int MAP_HEIGHT = 32;
  localparam int CELL_SHIFT = 4;
  localparam int MAX_STEPS  = 32;
  localparam int CELL_SIZE  = 1 << CELL_SHIFT;

  // map store
  localparam int DEPTH  = 1024;
  localparam int ADDR_W = 10;
  localparam int CODE_W = 3;
  localparam int COL_W  = $clog2(MAP_WIDTH);

  // item field widths
  localparam int POS_W  = 9;
  localparam int ANG_W  = 16;
  localparam int PATH_W = 24;

  // spans along each axis in world units
  localparam int SPAN_X  = MAP_WIDTH * CELL_SIZE;
  localparam int SPAN_Y  = MAP_HEIGHT * CELL_SIZE;
  localparam int SPAN_MX = (SPAN_X > SPAN_Y) ? SPAN_X : SPAN_Y;
  localparam int SPAN_W  = $clog2(SPAN_MX);
  localparam int P_W     = SPAN_W + 1;
  localparam int FRAC    = 16;
  localparam int Q_W     = SPAN_W + FRAC;
  localparam int D_W     = CELL_SHIFT + 2;
  localparam int AD_W    = CELL_SHIFT + 1;

  // cordic and divider
  localparam int CORDIC_ROUNDS = 24;
  localparam int ITER_W        = $clog2(CORDIC_ROUNDS);
  localparam int XY_W          = 34;
  localparam int CORDIC_GAIN   = 652032874;
  localparam int DIV_W         = XY_W + FRAC;
  localparam int LEN_SHIFT     = 46;

  // distance accumulator, capped at 2^40
  localparam int ACC_W     = 41;
  localparam int PROD_W    = DIV_W + AD_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam longint ACC_CAP = 64'd1 << 40;
  localparam longint OUT_MAX = (64'd1 << PATH_W) - 1;
  localparam longint MISS_RAW = 64'd1000000 * 256;
  localparam longint MISS_LEN = (MISS_RAW > OUT_MAX) ? OUT_MAX : MISS_RAW;

  // shared sequencing counter
  localparam int CNT_W = ADDR_W;

  // item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CAST  = 1'b1;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] cell_index;
    logic [CODE_W-1:0] cell_value;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [ANG_W-1:0]  ray_angle;
    logic              vertical_lines;
  } grc_in_t;

  typedef struct packed {
    logic [PATH_W-1:0] path_length;
    logic [CODE_W-1:0] wall_code;
    logic              hit;
  } grc_res_t;

  // controller to datapath and map
  typedef struct packed {
    logic              clear;
    logic [ADDR_W-1:0] clear_addr;
    logic              mem_wr;
    logic              load;
    logic              cordic;
    logic [ITER_W-1:0] iter;
    logic              div_init;
    logic              div_step;
    logic              step_d;
    logic              step_m;
    logic              step_a;
    logic              fin_hit;
    logic              fin_miss;
  } grc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic a_zero;
    logic wall_nz;
  } grc_stat_t;

  // arctangent of 2^-i in turns scaled by 2^32
  function automatic logic signed [XY_W-1:0] atan_step(input logic [ITER_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051D;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2E;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return $signed({{(XY_W-32){1'b0}}, v});
  endfunction

endpackage

@@ sv/grc_map.sv @@
// ----------------------------------------------------------------------------
// grc_map: wall code store
// Single write port shared by the reset clear sweep and write items, one
// registered read port for the ray stepper.
// ----------------------------------------------------------------------------
module grc_map (
  input  logic                       clk_i,
  input  logic                       clear_i,
  input  logic [grc_pkg::ADDR_W-1:0] clear_addr_i,
  input  logic                       wr_i,
  input  logic [grc_pkg::ADDR_W-1:0] wr_addr_i,
  input  logic [grc_pkg::CODE_W-1:0] wr_data_i,
  input  logic [grc_pkg::ADDR_W-1:0] rd_addr_i,
  output logic [grc_pkg::CODE_W-1:0] rd_data_o
);

  logic [grc_pkg::CODE_W-1:0] mem [grc_pkg::DEPTH];
  logic [grc_pkg::CODE_W-1:0] rd_data_q;
  logic                       we;
  logic [grc_pkg::ADDR_W-1:0] waddr;
  logic [grc_pkg::CODE_W-1:0] wdata;

  // clear sweep has priority over item writes
  assign we    = clear_i | wr_i;
  assign waddr = clear_i ? clear_addr_i : wr_addr_i;
  assign wdata = clear_i ? '0 : wr_data_i;

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ sv/grc_ctrl.sv @@
// ----------------------------------------------------------------------------
// grc_ctrl: sequencer of the grid ray caster
// Runs the reset clear sweep, cordic rounds, divider bits and the four
// phases of each cell crossing, and raises the result strobe.
// ----------------------------------------------------------------------------
module grc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                func_i,
  input  grc_pkg::grc_stat_t  stat_i,
  output grc_pkg::grc_cmd_t   cmd_o,
  output logic                busy,
  output logic                done_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CORDIC, S_CHECK, S_DIVIDE,
    S_STEP_D, S_STEP_M, S_STEP_A, S_STEP_T
  } state_e;

  state_e                    state_q, state_d;
  logic [grc_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      done_q, done_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    cmd_o.clear_addr = cnt_q[grc_pkg::ADDR_W-1:0];
    cmd_o.iter       = cnt_q[grc_pkg::ITER_W-1:0];
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == grc_pkg::CNT_W'(grc_pkg::DEPTH - 1)) begin
          state_d = S_IDLE;
          cnt_d   = '0;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (func_i == grc_pkg::FUNC_CAST) begin
            cmd_o.load = 1'b1;
            cnt_d   = '0;
            state_d = S_CORDIC;
          end else begin
            cmd_o.mem_wr = 1'b1;
          end
        end
      end
      S_CORDIC: begin
        cmd_o.cordic = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == grc_pkg::CNT_W'(grc_pkg::CORDIC_ROUNDS - 1)) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cnt_d = '0;
        if (stat_i.a_zero) begin
          cmd_o.fin_miss = 1'b1;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == grc_pkg::CNT_W'(grc_pkg::DIV_W - 1)) begin
          cnt_d   = '0;
          state_d = S_STEP_D;
        end
      end
      S_STEP_D: begin
        cmd_o.step_d = 1'b1;
        state_d = S_STEP_M;
      end
      S_STEP_M: begin
        cmd_o.step_m = 1'b1;
        state_d = S_STEP_A;
      end
      S_STEP_A: begin
        cmd_o.step_a = 1'b1;
        state_d = S_STEP_T;
      end
      S_STEP_T: begin
        if (stat_i.wall_nz) begin
          cmd_o.fin_hit = 1'b1;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (cnt_q == grc_pkg::CNT_W'(grc_pkg::MAX_STEPS - 1)) begin
          cmd_o.fin_miss = 1'b1;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_STEP_D;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state, counter and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

@@ sv/grc_dp.sv @@
// ----------------------------------------------------------------------------
// grc_dp: datapath of the grid ray caster
// Shared cordic rotator, bit-serial divider for slope and segment length,
// cell crossing stepper with distance accumulator and result register.
// ----------------------------------------------------------------------------
module grc_dp (
  input  logic                       clk_i,
  input  grc_pkg::grc_in_t           in_i,
  input  grc_pkg::grc_cmd_t          cmd_i,
  input  logic [grc_pkg::CODE_W-1:0] rd_data_i,
  output logic [grc_pkg::ADDR_W-1:0] rd_addr_o,
  output grc_pkg::grc_stat_t         stat_o,
  output grc_pkg::grc_res_t          res_o
);

  localparam int XY_W  = grc_pkg::XY_W;
  localparam int DIV_W = grc_pkg::DIV_W;
  localparam int P_W   = grc_pkg::P_W;
  localparam int Q_W   = grc_pkg::Q_W;
  localparam int D_W   = grc_pkg::D_W;
  localparam int AD_W  = grc_pkg::AD_W;
  localparam int NP_W  = P_W + 1;
  localparam logic [P_W-1:0] PMASK_X = P_W'(grc_pkg::SPAN_X - 1);
  localparam logic [P_W-1:0] PMASK_Y = P_W'(grc_pkg::SPAN_Y - 1);
  localparam logic [Q_W-1:0] QMASK_X = Q_W'((longint'(grc_pkg::SPAN_X) << grc_pkg::FRAC) - 1);
  localparam logic [Q_W-1:0] QMASK_Y = Q_W'((longint'(grc_pkg::SPAN_Y) << grc_pkg::FRAC) - 1);

  // cordic state
  logic signed [XY_W-1:0] x_q, y_q, z_q;
  logic                   flip_q, vert_q;
  // divider state
  logic [XY_W-1:0]  den_q, rem_b_q, rem_l_q;
  logic [DIV_W-1:0] num_b_q, num_l_q;
  logic             neg_q, fwd_q;
  // stepper state
  logic [P_W-1:0]              p_q, pn_q;
  logic [Q_W-1:0]              q_q, qinc_q;
  logic signed [D_W-1:0]       d_q;
  logic [AD_W-1:0]             ad_q;
  logic [grc_pkg::PROD_W-1:0]  prod_q;
  logic [grc_pkg::ACC_W-1:0]   acc_q;
  grc_pkg::grc_res_t           res_q;

  // start phase with the half turn fold
  logic [31:0] phase, phase_f;
  logic        flip;
  always_comb begin
    phase   = {in_i.ray_angle, 16'h0000};
    flip    = (phase - 32'h4000_0000) < 32'h8000_0000;
    phase_f = flip ? (phase - 32'h8000_0000) : phase;
  end

  // one cordic rotation
  logic signed [XY_W-1:0] xs, ys, atan;
  always_comb begin
    xs   = x_q >>> cmd_i.iter;
    ys   = y_q >>> cmd_i.iter;
    atan = grc_pkg::atan_step(cmd_i.iter);
  end

  // ray components across and along the tested lines
  logic signed [XY_W-1:0] cx, sy, a, b;
  logic [XY_W-1:0]        a_abs, b_abs;
  always_comb begin
    cx    = flip_q ? -x_q : x_q;
    sy    = flip_q ? -y_q : y_q;
    a     = vert_q ? cx : sy;
    b     = vert_q ? sy : cx;
    a_abs = a[XY_W-1] ? XY_W'(-a) : XY_W'(a);
    b_abs = b[XY_W-1] ? XY_W'(-b) : XY_W'(b);
  end

  // restoring divider, slope and length lanes share the divisor
  logic [XY_W:0] trial_b, trial_l;
  logic          ge_b, ge_l;
  always_comb begin
    trial_b = {rem_b_q, num_b_q[DIV_W-1]};
    trial_l = {rem_l_q, num_l_q[DIV_W-1]};
    ge_b    = trial_b >= {1'b0, den_q};
    ge_l    = trial_l >= {1'b0, den_q};
  end

  // next crossing and move length
  logic signed [NP_W-1:0] p_s, t, np, np_b, dd;
  logic [P_W-1:0]         pmask, pn;
  always_comb begin
    p_s   = $signed({1'b0, p_q});
    t     = fwd_q ? (p_s + NP_W'(grc_pkg::CELL_SIZE)) : (p_s - NP_W'(1));
    np    = t & ~NP_W'(grc_pkg::CELL_SIZE - 1);
    dd    = np - p_s;
    np_b  = np - NP_W'(!fwd_q);
    pmask = vert_q ? PMASK_X : PMASK_Y;
    pn    = (np_b[P_W-1:0] & pmask) + P_W'(!fwd_q);
  end

  // signed slope, only its low bits matter after the wrap
  logic [Q_W-1:0] ratio, d_ext;
  always_comb begin
    ratio = neg_q ? Q_W'(~num_b_q + 1'b1) : num_b_q[Q_W-1:0];
    d_ext = Q_W'($signed(d_q));
  end

  // accumulate, wrap and form the map address
  logic [Q_W-1:0]             qmask, q_new;
  logic [grc_pkg::SUM_W-1:0]  acc_sum;
  logic [grc_pkg::ACC_W-1:0]  acc_new;
  logic [P_W-1:0]             pc_full;
  logic [P_W-1:0]             pc;
  logic [Q_W-1:0]             qc;
  logic [P_W-1:0]             col, row;
  always_comb begin
    qmask   = vert_q ? QMASK_Y : QMASK_X;
    q_new   = (q_q + qinc_q) & qmask;
    acc_sum = grc_pkg::SUM_W'(acc_q) + grc_pkg::SUM_W'(prod_q);
    acc_new = (acc_sum > grc_pkg::SUM_W'(grc_pkg::ACC_CAP)) ?
              grc_pkg::ACC_W'(grc_pkg::ACC_CAP) : acc_sum[grc_pkg::ACC_W-1:0];
    pc_full = pn_q >> grc_pkg::CELL_SHIFT;
    pc      = pc_full - P_W'(!fwd_q);
    qc      = q_new >> (grc_pkg::FRAC + grc_pkg::CELL_SHIFT);
    col     = vert_q ? pc : qc[P_W-1:0];
    row     = vert_q ? qc[P_W-1:0] : pc;
    rd_addr_o = grc_pkg::ADDR_W'((row << grc_pkg::COL_W) + col);
  end

  // status to the controller
  assign stat_o.a_zero  = (a == '0);
  assign stat_o.wall_nz = (rd_data_i != '0);

  // saturated distance
  logic [grc_pkg::ACC_W-9:0]  dist_raw;
  logic [grc_pkg::PATH_W-1:0] dist_sat;
  always_comb begin
    dist_raw = acc_q[grc_pkg::ACC_W-1:8];
    dist_sat = (dist_raw > (grc_pkg::ACC_W-8)'(grc_pkg::OUT_MAX)) ?
               grc_pkg::PATH_W'(grc_pkg::OUT_MAX) : dist_raw[grc_pkg::PATH_W-1:0];
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q    <= XY_W'(grc_pkg::CORDIC_GAIN);
      y_q    <= '0;
      z_q    <= XY_W'($signed(phase_f));
      flip_q <= flip;
      vert_q <= in_i.vertical_lines;
      acc_q  <= '0;
      if (in_i.vertical_lines) begin
        p_q <= P_W'(in_i.pos_x);
        q_q <= Q_W'(in_i.pos_y) << grc_pkg::FRAC;
      end else begin
        p_q <= P_W'(in_i.pos_y);
        q_q <= Q_W'(in_i.pos_x) << grc_pkg::FRAC;
      end
    end
    if (cmd_i.cordic) begin
      if (!z_q[XY_W-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan;
      end
    end
    if (cmd_i.div_init) begin
      den_q   <= a_abs;
      rem_b_q <= '0;
      rem_l_q <= '0;
      num_b_q <= DIV_W'(b_abs) << grc_pkg::FRAC;
      num_l_q <= DIV_W'(1) << grc_pkg::LEN_SHIFT;
      neg_q   <= a[XY_W-1] ^ b[XY_W-1];
      fwd_q   <= !a[XY_W-1];
    end
    if (cmd_i.div_step) begin
      rem_b_q <= ge_b ? XY_W'(trial_b - {1'b0, den_q}) : trial_b[XY_W-1:0];
      rem_l_q <= ge_l ? XY_W'(trial_l - {1'b0, den_q}) : trial_l[XY_W-1:0];
      num_b_q <= {num_b_q[DIV_W-2:0], ge_b};
      num_l_q <= {num_l_q[DIV_W-2:0], ge_l};
    end
    if (cmd_i.step_d) begin
      d_q  <= D_W'(dd);
      ad_q <= dd[NP_W-1] ? AD_W'(-dd) : AD_W'(dd);
      pn_q <= pn;
    end
    if (cmd_i.step_m) begin
      prod_q <= grc_pkg::PROD_W'(ad_q) * grc_pkg::PROD_W'(num_l_q);
      qinc_q <= Q_W'(ratio * d_ext);
    end
    if (cmd_i.step_a) begin
      q_q   <= q_new;
      acc_q <= acc_new;
      p_q   <= pn_q;
    end
    if (cmd_i.fin_hit) begin
      res_q.path_length <= dist_sat;
      res_q.wall_code   <= rd_data_i;
      res_q.hit         <= 1'b1;
    end
    if (cmd_i.fin_miss) begin
      res_q.path_length <= grc_pkg::PATH_W'(grc_pkg::MISS_LEN);
      res_q.wall_code   <= '0;
      res_q.hit         <= 1'b0;
    end
  end

  assign res_o = res_q;

endmodule

@@ sv/grid_raycast_wall_distance.sv @@
// ----------------------------------------------------------------------------
// grid_raycast_wall_distance: wall distance along a ray over a wrapping map
// Command-style item port, one result strobe per cast item.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a rising edge with start high and busy low.
//   func 0 writes one map cell in that cycle; busy stays low and no result
//   follows. func 1 casts a ray; busy rises on the next cycle.
//   A cast runs the cordic rounds, a check step and the divider (one
//   quotient bit a cycle for slope and segment length), then the phases of
//   each cell crossing (move, multiply, accumulate with map read, test), at
//   most 32 crossings. done_o pulses in the cycle after the last of these;
//   a ray parallel to the lines skips the divider and the crossings. busy
//   falls together with the strobe, and the next item may be taken in that
//   same cycle.
//   Each result appears on res_o in the cycle done_o is high and is held
//   until the next result; the receiver cannot stall it and must take it then.
//   After reset the map store is swept to zero, one cell a cycle, over all
//   1024 cells with busy high; no item is taken before the sweep ends.
// ----------------------------------------------------------------------------
module grid_raycast_wall_distance (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  grc_pkg::grc_in_t  in_i,
  output logic              busy,
  output logic              done_o,
  output grc_pkg::grc_res_t res_o
);

  grc_pkg::grc_cmd_t          cmd;
  grc_pkg::grc_stat_t         stat;
  logic [grc_pkg::ADDR_W-1:0] rd_addr;
  logic [grc_pkg::CODE_W-1:0] rd_data;

  // sequencer
  grc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (in_i.func),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  // arithmetic and stepping
  grc_dp u_dp (
    .clk_i     (clk_i),
    .in_i      (in_i),
    .cmd_i     (cmd),
    .rd_data_i (rd_data),
    .rd_addr_o (rd_addr),
    .stat_o    (stat),
    .res_o     (res_o)
  );

  // wall code store
  grc_map u_map (
    .clk_i        (clk_i),
    .clear_i      (cmd.clear),
    .clear_addr_i (cmd.clear_addr),
    .wr_i         (cmd.mem_wr),
    .wr_addr_i    (in_i.cell_index),
    .wr_data_i    (in_i.cell_value),
    .rd_addr_i    (rd_addr),
    .rd_data_o    (rd_data)
  );

endmodule

@@ sv/grc_checker.sv @@
// ----------------------------------------------------------------------------
// grc_checker: port-level checks of the grid ray caster
// Watches the item and result ports; bound to the top level.
// ----------------------------------------------------------------------------
module grc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input grc_pkg::grc_in_t  in_i,
  input logic              busy,
  input logic              done_o,
  input grc_pkg::grc_res_t res_o
);

  // a cast item keeps the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_i.func == grc_pkg::FUNC_CAST) |=> busy)
    else $error("cast item did not raise busy");

  // a write item never causes a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_i.func == grc_pkg::FUNC_WRITE) |=> !done_o)
    else $error("result after a write item");

  // strobe lasts one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // a miss carries the miss distance and no code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.hit) |->
      (res_o.path_length == grc_pkg::PATH_W'(grc_pkg::MISS_LEN) && res_o.wall_code == '0))
    else $error("miss result malformed");

  // a hit names a wall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.hit) |-> (res_o.wall_code != '0))
    else $error("hit with empty wall code");

endmodule

bind grid_raycast_wall_distance grc_checker u_grc_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .in_i   (in_i),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);
